[design/hsv2rgb_pkg.sv]
package hsv2rgb_pkg;

  localparam int unsigned HUE_W           = 16;
  localparam int unsigned CHAN_W          = 17;
  localparam int unsigned HUE_FRAC_BITS   = 13;
  localparam int unsigned CHAN_FRAC_BITS  = 16;

  localparam int unsigned K_W             = 30;
  localparam int unsigned HK_W            = HUE_W + K_W;
  localparam int unsigned HP_W            = 19;
  localparam int unsigned SECT_W          = HP_W - CHAN_FRAC_BITS;
  localparam int unsigned PROD_W          = 2 * CHAN_W;
  localparam int unsigned HP_SHIFT        = 30 + HUE_FRAC_BITS - CHAN_FRAC_BITS;

  localparam int unsigned S_DATA_W        = 56;
  localparam int unsigned M_DATA_W        = 56;

  localparam logic [63:0] SCALE_K_64 =
      (64'd3 * 64'd1073741824 * 64'd100000000 + 64'd157079632) / 64'd314159265;
  localparam logic [K_W-1:0] SCALE_K = SCALE_K_64[K_W-1:0];

  localparam logic [CHAN_W-1:0] ONE       = CHAN_W'(1) << CHAN_FRAC_BITS;
  localparam logic [PROD_W-1:0] HALF      = PROD_W'(1) << (CHAN_FRAC_BITS - 1);
  localparam int unsigned       TOL_INT   = ((1 << CHAN_FRAC_BITS) + 500) / 1000;
  localparam logic [HP_W-1:0]   SIX       = HP_W'(6) << CHAN_FRAC_BITS;
  localparam logic [HP_W-1:0]   SIX_LO    = SIX - HP_W'(TOL_INT);
  localparam logic [HP_W-1:0]   SIX_HI    = SIX + HP_W'(TOL_INT);

  typedef enum logic [SECT_W-1:0] {
    SECT_RY   = 3'd0,
    SECT_YG   = 3'd1,
    SECT_GC   = 3'd2,
    SECT_CB   = 3'd3,
    SECT_BM   = 3'd4,
    SECT_MR   = 3'd5,
    SECT_GR6  = 3'd6,
    SECT_GR7  = 3'd7
  } sector_e;

endpackage

[design/hsv_to_rgb_converter_unit.sv]
// An input transfer is registered through stages 1 to 4, in order, to the
// master side (four register stages).
// Throughput: one item per cycle; each of the four stages holds its item
// while the stage after it is full and stalled, so bubbles still fill.
// The multipliers sit in stages 1 and 3, so no stage limits the rate.
// Reset: rst_ni is asynchronous, active low, and clears all stage valid bits.
module hsv_to_rgb_converter_unit
  import hsv2rgb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [15:0] hue, [32:16] saturation, [49:33] brightness, [55:50] zero
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [16:0] red, [33:17] green, [50:34] blue, [55:51] zero
  output logic [M_DATA_W-1:0] m_axis_tdata
);

  logic vld1_q, vld2_q, vld3_q, vld4_q;
  logic en1, en2, en3, en4;

  assign en4 = !vld4_q || m_axis_tready;
  assign en3 = !vld3_q || en4;
  assign en2 = !vld2_q || en3;
  assign en1 = !vld1_q || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      if (en1) vld1_q <= s_axis_tvalid;
      if (en2) vld2_q <= vld1_q;
      if (en3) vld3_q <= vld2_q;
      if (en4) vld4_q <= vld3_q;
    end
  end

  // stage 1: saturate, V*S and hue*K
  logic [HUE_W-1:0]  hue_in;
  logic [CHAN_W-1:0] sat_in, val_in, sat_c, val_c;
  logic [PROD_W-1:0] vs1_d, vs1_q;
  logic [HK_W-1:0]   hk1_d, hk1_q;
  logic [CHAN_W-1:0] v1_q;

  assign hue_in = s_axis_tdata[HUE_W-1:0];
  assign sat_in = s_axis_tdata[HUE_W+CHAN_W-1:HUE_W];
  assign val_in = s_axis_tdata[HUE_W+2*CHAN_W-1:HUE_W+CHAN_W];
  assign sat_c  = (sat_in > ONE) ? ONE : sat_in;
  assign val_c  = (val_in > ONE) ? ONE : val_in;
  assign vs1_d  = PROD_W'(val_c) * PROD_W'(sat_c);
  assign hk1_d  = HK_W'(hue_in) * HK_W'(SCALE_K);

  // stage 2: chroma, offset, sector position with wrap
  logic [PROD_W-1:0] vs_rnd;
  logic [HP_W-1:0]   hp_raw, hp_w;
  logic [CHAN_W-1:0] c2_d, c2_q, m2_d, m2_q;
  logic [SECT_W-1:0] sect2_q;
  logic [CHAN_FRAC_BITS-1:0] frac2_q;

  assign vs_rnd = vs1_q + HALF;
  assign c2_d   = vs_rnd[CHAN_FRAC_BITS+CHAN_W-1:CHAN_FRAC_BITS];
  assign m2_d   = v1_q - c2_d;
  assign hp_raw = hk1_q[HP_SHIFT+HP_W-1:HP_SHIFT];
  assign hp_w   = (hp_raw >= SIX_LO && hp_raw <= SIX_HI) ? '0 : hp_raw;

  // stage 3: second component product
  logic [CHAN_W-1:0] opnd;
  logic [PROD_W-1:0] xp3_d, xp3_q;
  logic [CHAN_W-1:0] c3_q, m3_q;
  logic [SECT_W-1:0] sect3_q;

  assign opnd  = sect2_q[0] ? (ONE - CHAN_W'(frac2_q)) : CHAN_W'(frac2_q);
  assign xp3_d = PROD_W'(c2_q) * PROD_W'(opnd);

  // stage 4: place chroma and second component, add offset
  logic [PROD_W-1:0] x_rnd;
  logic [CHAN_W-1:0] x3, r_d, g_d, b_d, r_q, g_q, b_q;
  logic [CHAN_W-1:0] r1, g1, b1;

  assign x_rnd = xp3_q + HALF;
  assign x3    = x_rnd[CHAN_FRAC_BITS+CHAN_W-1:CHAN_FRAC_BITS];

  always_comb begin
    r1 = '0;
    g1 = '0;
    b1 = '0;
    case (sector_e'(sect3_q))
      SECT_RY: begin r1 = c3_q; g1 = x3;   end
      SECT_YG: begin r1 = x3;   g1 = c3_q; end
      SECT_GC: begin g1 = c3_q; b1 = x3;   end
      SECT_CB: begin g1 = x3;   b1 = c3_q; end
      SECT_BM: begin r1 = x3;   b1 = c3_q; end
      SECT_MR: begin r1 = c3_q; b1 = x3;   end
      default: begin r1 = '0;   g1 = '0;   b1 = '0; end
    endcase
  end

  assign r_d = r1 + m3_q;
  assign g_d = g1 + m3_q;
  assign b_d = b1 + m3_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      vs1_q <= vs1_d;
      hk1_q <= hk1_d;
      v1_q  <= val_c;
    end
    if (en2) begin
      c2_q    <= c2_d;
      m2_q    <= m2_d;
      sect2_q <= hp_w[HP_W-1:CHAN_FRAC_BITS];
      frac2_q <= hp_w[CHAN_FRAC_BITS-1:0];
    end
    if (en3) begin
      xp3_q   <= xp3_d;
      c3_q    <= c2_q;
      m3_q    <= m2_q;
      sect3_q <= sect2_q;
    end
    if (en4) begin
      r_q <= r_d;
      g_q <= g_d;
      b_q <= b_d;
    end
  end

  assign m_axis_tvalid = vld4_q;
  assign m_axis_tdata  = {(M_DATA_W - 3*CHAN_W)'(0), b_q, g_q, r_q};

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld1_q |-> s_axis_tready)
    else $error("input not ready with stage 1 empty");

  a_chroma_le_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld2_q |-> (c2_q <= ONE && m2_q <= ONE))
    else $error("chroma or offset out of range");

  a_stage3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld3_q && !en3) |=> ($stable(xp3_q) && $stable(sect3_q) && vld3_q))
    else $error("stage 3 lost data during stall");

  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en4 && vld3_q && sect3_q[2] && sect3_q[1]) |=> (r_q == g_q && g_q == b_q))
    else $error("hue past sixth sector not grey");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld4_q |-> (r_q <= ONE && g_q <= ONE && b_q <= ONE))
    else $error("channel out of range");

endmodule
